### design/lle_pkg.sv
// ----------------------------------------------------------------------------
// lle_pkg: shared types and constants of the lcs length engine
// request payload structs, command codes and default sizes
// ----------------------------------------------------------------------------
package lle_pkg;

    // default longest string that is stored
    localparam int LLE_MAX_LEN_DEF = 64;

    // fixed field widths
    localparam int LLE_SYM_W = 8;
    localparam int LLE_LEN_W = 7;

    // command codes
    localparam logic CMD_STR_A = 1'b0;
    localparam logic CMD_STR_B = 1'b1;

    // input request
    typedef struct packed {
        logic                 command;
        logic [LLE_SYM_W-1:0] symbol;
        logic                 last_symbol;
    } t_lle_in;

    // result request
    typedef struct packed {
        logic [LLE_LEN_W-1:0] match_length;
        logic                 truncated;
    } t_lle_out;

endpackage

### design/lle_ram.sv
// ----------------------------------------------------------------------------
// lle_ram: simple dual port synchronous ram
// one write port, one read port with registered read data and read enable
// ----------------------------------------------------------------------------
module lle_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 64,
    parameter int ADR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADR_W-1:0]  i_wa,
    input  logic [DATA_W-1:0] i_wd,
    input  logic              i_re,
    input  logic [ADR_W-1:0]  i_ra,
    output logic [DATA_W-1:0] o_rd
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd <= r_mem[i_ra];
        end
    end

    assign o_rd = r_rd;

endmodule

### design/lle_fill_ctrl.sv
// ----------------------------------------------------------------------------
// lle_fill_ctrl: table fill sequencer and result register
// walks rows of string a and cells of string b, read-modify-write of dp row
// ----------------------------------------------------------------------------
module lle_fill_ctrl
    import lle_pkg::*;
#(
    parameter int MAX_LEN = LLE_MAX_LEN_DEF,
    parameter int CNT_W   = $clog2(MAX_LEN + 1),
    parameter int ADR_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // fill start from the loader
    input  logic                 i_start,
    input  logic [CNT_W-1:0]     i_len_a,
    input  logic [CNT_W-1:0]     i_len_b,
    input  logic                 i_trunc,
    output logic                 o_busy,
    // string a read port
    output logic                 o_a_re,
    output logic [ADR_W-1:0]     o_a_ra,
    input  logic [LLE_SYM_W-1:0] i_a_rd,
    // string b read port
    output logic                 o_b_re,
    output logic [ADR_W-1:0]     o_b_ra,
    input  logic [LLE_SYM_W-1:0] i_b_rd,
    // dp row ports
    output logic                 o_dp_we,
    output logic [ADR_W-1:0]     o_dp_wa,
    output logic [CNT_W-1:0]     o_dp_wd,
    output logic                 o_dp_re,
    output logic [ADR_W-1:0]     o_dp_ra,
    input  logic [CNT_W-1:0]     i_dp_rd,
    // result channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_lle_out             o_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROW,
        S_CELL,
        S_HOLD
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_ca, n_ca;
    logic [CNT_W-1:0] r_cb, n_cb;
    logic             r_trunc, n_trunc;
    logic [CNT_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_j, n_j;
    logic [ADR_W-1:0] r_wa, n_wa;
    logic             r_vld, n_vld;
    logic             r_first, n_first;
    logic [CNT_W-1:0] r_left, n_left;
    logic [CNT_W-1:0] r_diag, n_diag;
    logic [CNT_W-1:0] r_res, n_res;
    logic             r_out_vld, n_out_vld;
    t_lle_out         r_out, n_out;

    logic                   issue;
    logic                   row_end;
    logic                   last_row;
    logic [CNT_W-1:0]       up;
    logic [CNT_W-1:0]       cell_val;
    logic [CNT_W+LLE_LEN_W-1:0] res_ext;

    // cell datapath: match takes diagonal plus one, else max of up and left
    always_comb begin
        up = r_first ? '0 : i_dp_rd;
        if (i_a_rd == i_b_rd) begin
            cell_val = r_diag + 1'b1;
        end else begin
            cell_val = (up > r_left) ? up : r_left;
        end
    end

    assign issue    = (r_state == S_CELL) && (r_j < r_cb);
    assign row_end  = (r_state == S_CELL) && r_vld && (r_j == r_cb);
    assign last_row = ((r_i + 1'b1) == r_ca);
    assign res_ext  = {{LLE_LEN_W{1'b0}}, r_res};

    // memory ports
    assign o_a_re  = (r_state == S_ROW);
    assign o_a_ra  = r_i[ADR_W-1:0];
    assign o_b_re  = issue;
    assign o_b_ra  = r_j[ADR_W-1:0];
    assign o_dp_re = issue;
    assign o_dp_ra = r_j[ADR_W-1:0];
    assign o_dp_we = (r_state == S_CELL) && r_vld;
    assign o_dp_wa = r_wa;
    assign o_dp_wd = cell_val;

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    // next state
    always_comb begin
        n_state   = r_state;
        n_ca      = r_ca;
        n_cb      = r_cb;
        n_trunc   = r_trunc;
        n_i       = r_i;
        n_j       = r_j;
        n_wa      = r_wa;
        n_vld     = 1'b0;
        n_first   = r_first;
        n_left    = r_left;
        n_diag    = r_diag;
        n_res     = r_res;
        n_out_vld = r_out_vld && i_stall;
        n_out     = r_out;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_ca    = i_len_a;
                    n_cb    = i_len_b;
                    n_trunc = i_trunc;
                    n_i     = '0;
                    n_first = 1'b1;
                    n_res   = '0;
                    n_state = (i_len_a == '0) ? S_HOLD : S_ROW;
                end
            end
            S_ROW: begin
                // string a symbol of this row is read here
                n_j     = '0;
                n_left  = '0;
                n_diag  = '0;
                n_state = S_CELL;
            end
            S_CELL: begin
                if (issue) begin
                    n_wa  = r_j[ADR_W-1:0];
                    n_j   = r_j + 1'b1;
                    n_vld = 1'b1;
                end
                if (r_vld) begin
                    n_left = cell_val;
                    n_diag = up;
                end
                if (row_end) begin
                    if (last_row) begin
                        n_res   = cell_val;
                        n_state = S_HOLD;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_first = 1'b0;
                        n_state = S_ROW;
                    end
                end
            end
            S_HOLD: begin
                if (!r_out_vld || !i_stall) begin
                    n_out_vld          = 1'b1;
                    n_out.match_length = res_ext[LLE_LEN_W-1:0];
                    n_out.truncated    = r_trunc;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_vld     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_vld     <= n_vld;
            r_out_vld <= n_out_vld;
        end
        r_ca    <= n_ca;
        r_cb    <= n_cb;
        r_trunc <= n_trunc;
        r_i     <= n_i;
        r_j     <= n_j;
        r_wa    <= n_wa;
        r_first <= n_first;
        r_left  <= n_left;
        r_diag  <= n_diag;
        r_res   <= n_res;
        r_out   <= n_out;
    end

`ifndef SYNTH
    // a dp entry is never read in the cycle it is written
    a_no_dp_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dp_we && o_dp_re |-> o_dp_wa != o_dp_ra)
        else $error("dp row read and write hit the same entry");

    // cell index stays inside string b
    a_j_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CELL |-> r_j <= r_cb)
        else $error("cell index beyond string b length");

    // a cell value never exceeds the length of string b
    a_val_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dp_we |-> o_dp_wd <= r_cb)
        else $error("dp value exceeds string b length");

    // the cell walk enters the result hold state only at the end of the last row
    a_idle_via_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CELL && n_state == S_HOLD |-> row_end && last_row)
        else $error("fill left the cell walk early");
`endif

endmodule

### design/lcs_length_engine.sv
// result: valid once the fill started by the final string b request is done; input
//   stall drops in the same cycle that the result becomes valid
// throughput: one symbol request per cycle while loading; a fill stalls input
// reset: synchronous active low, clears string lengths, overflow and fsm state
// ----------------------------------------------------------------------------
// lcs_length_engine: longest common subsequence length of two byte strings
// loads both strings into memories, then fills the dp row one cell a cycle
// ----------------------------------------------------------------------------
module lcs_length_engine
    import lle_pkg::*;
#(
    parameter int MAX_LEN = LLE_MAX_LEN_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    // symbol requests
    input  logic     i_valid,
    output logic     o_stall,
    input  t_lle_in  i_data,
    // result requests
    output logic     o_valid,
    input  logic     i_stall,
    output t_lle_out o_data
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int ADR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    logic [CNT_W-1:0] r_count_a, n_count_a;
    logic [CNT_W-1:0] r_count_b, n_count_b;
    logic             r_ovf, n_ovf;

    logic                 accept;
    logic                 a_full;
    logic                 b_full;
    logic                 a_we;
    logic                 b_we;
    logic                 start;
    logic [CNT_W-1:0]     len_b;
    logic                 trunc;
    logic                 busy;

    logic                 a_re, b_re, dp_re, dp_we;
    logic [ADR_W-1:0]     a_ra, b_ra, dp_ra, dp_wa;
    logic [LLE_SYM_W-1:0] a_rd, b_rd;
    logic [CNT_W-1:0]     dp_rd, dp_wd;

    assign o_stall = busy;
    assign accept  = i_valid && !busy;
    assign a_full  = (r_count_a == CNT_W'(MAX_LEN));
    assign b_full  = (r_count_b == CNT_W'(MAX_LEN));
    assign a_we    = accept && (i_data.command == CMD_STR_A) && !a_full;
    assign b_we    = accept && (i_data.command == CMD_STR_B) && !b_full;

    // final string b symbol starts the fill
    assign start = accept && (i_data.command == CMD_STR_B) && i_data.last_symbol;
    assign len_b = b_full ? r_count_b : r_count_b + 1'b1;
    assign trunc = r_ovf || b_full;

    // string lengths and overflow
    always_comb begin
        n_count_a = r_count_a;
        n_count_b = r_count_b;
        n_ovf     = r_ovf;
        if (a_we) begin
            n_count_a = r_count_a + 1'b1;
        end
        if (b_we) begin
            n_count_b = r_count_b + 1'b1;
        end
        if (accept && ((i_data.command == CMD_STR_A) ? a_full : b_full)) begin
            n_ovf = 1'b1;
        end
        if (start) begin
            n_count_a = '0;
            n_count_b = '0;
            n_ovf     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_a <= '0;
            r_count_b <= '0;
            r_ovf     <= 1'b0;
        end else begin
            r_count_a <= n_count_a;
            r_count_b <= n_count_b;
            r_ovf     <= n_ovf;
        end
    end

    // string a store
    lle_ram #(
        .DATA_W (LLE_SYM_W),
        .DEPTH  (MAX_LEN),
        .ADR_W  (ADR_W)
    ) u_str_a (
        .i_clk (i_clk),
        .i_we  (a_we),
        .i_wa  (r_count_a[ADR_W-1:0]),
        .i_wd  (i_data.symbol),
        .i_re  (a_re),
        .i_ra  (a_ra),
        .o_rd  (a_rd)
    );

    // string b store
    lle_ram #(
        .DATA_W (LLE_SYM_W),
        .DEPTH  (MAX_LEN),
        .ADR_W  (ADR_W)
    ) u_str_b (
        .i_clk (i_clk),
        .i_we  (b_we),
        .i_wa  (r_count_b[ADR_W-1:0]),
        .i_wd  (i_data.symbol),
        .i_re  (b_re),
        .i_ra  (b_ra),
        .o_rd  (b_rd)
    );

    // dp row, entry j-1 holds column j; column 0 is always zero
    lle_ram #(
        .DATA_W (CNT_W),
        .DEPTH  (MAX_LEN),
        .ADR_W  (ADR_W)
    ) u_dp_row (
        .i_clk (i_clk),
        .i_we  (dp_we),
        .i_wa  (dp_wa),
        .i_wd  (dp_wd),
        .i_re  (dp_re),
        .i_ra  (dp_ra),
        .o_rd  (dp_rd)
    );

    // fill sequencer
    lle_fill_ctrl #(
        .MAX_LEN (MAX_LEN),
        .CNT_W   (CNT_W),
        .ADR_W   (ADR_W)
    ) u_fill (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_len_a (r_count_a),
        .i_len_b (len_b),
        .i_trunc (trunc),
        .o_busy  (busy),
        .o_a_re  (a_re),
        .o_a_ra  (a_ra),
        .i_a_rd  (a_rd),
        .o_b_re  (b_re),
        .o_b_ra  (b_ra),
        .i_b_rd  (b_rd),
        .o_dp_we (dp_we),
        .o_dp_wa (dp_wa),
        .o_dp_wd (dp_wd),
        .o_dp_re (dp_re),
        .o_dp_ra (dp_ra),
        .i_dp_rd (dp_rd),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

`ifndef SYNTH
    // string lengths saturate at the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count_a <= CNT_W'(MAX_LEN) && r_count_b <= CNT_W'(MAX_LEN))
        else $error("string length beyond store depth");

    // lengths are cleared once a fill is started
    a_clear_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> r_count_a == '0 && r_count_b == '0 && !r_ovf)
        else $error("lengths not cleared after fill start");

    // no symbol is stored while a fill runs
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !a_we && !b_we)
        else $error("symbol stored during fill");
`endif

endmodule
